FILE: hw/rtl/active_sender_tracker_defines.svh
// assertion macros used by the tracker rtl
`ifndef ACTIVE_SENDER_TRACKER_DEFINES_SVH
`define ACTIVE_SENDER_TRACKER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define AST_ASSERT_IMPL(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

// next-cycle implication, quiet during reset
`define AST_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/ast_pkg.sv
`default_nettype none

package ast_pkg;

  // field widths
  localparam int unsigned IP_W       = 32;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WINDOW_W   = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COUNT_OUT_W = 4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_UP = 1'b1;

  // reset values
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd5000;
  localparam logic [PORT_W-1:0]   PORT_RESET   = 16'd4422;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_CONFLICT = 2'd1,
    MODE_IDLE     = 2'd2
  } mode_t;

  // one table row
  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] seen;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: hw/rtl/active_sender_tracker.sv
// active sender tracker: one request in flight at a time
// sequence: S_SCAN walks the table, S_TAIL settles the fill count, S_DONE loads the
//   result register once it is free; no new request is taken before S_DONE ends, and
//   the single-pass table walk goes through the one read port of the table ram
// reset: synchronous, active high; fill count and mode state cleared at once,
//   table contents left as they are (no clearing pass)
`default_nettype none
`include "active_sender_tracker_defines.svh"

module active_sender_tracker #(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [ast_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ast_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               action,
  input  wire logic [ast_pkg::IP_W-1:0]           src_addr,
  input  wire logic [ast_pkg::PORT_W-1:0]         src_port,
  input  wire logic [ast_pkg::TIME_W-1:0]         now_ms,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output ast_pkg::mode_t                          mode,
  output logic                                    mode_changed,
  output logic                                    remote_valid,
  output logic [ast_pkg::IP_W-1:0]                peer_addr,
  output logic [ast_pkg::PORT_W-1:0]              peer_port,
  output logic [ast_pkg::COUNT_OUT_W-1:0]         active_count,
  output logic                                    announce
);

  import ast_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,   // waiting for a request
    S_SCAN = 4'b0010,   // walk the table: match, expire, compact
    S_TAIL = 4'b0100,   // append a new sender, settle the fill count
    S_DONE = 4'b1000    // pick the mode and load the result register
  } state_t;

  state_t state;

  // configuration registers
  logic [WINDOW_W-1:0] window_ms;
  logic [TIME_W-1:0]   link_up_time_ms;

  // persistent tracker state
  logic [CW-1:0]     entry_count;
  logic [TIME_W-1:0] last_pixel_ms;
  mode_t             current_mode;

  // latched request
  logic              lat_pixel;
  logic [IP_W-1:0]   lat_ip;
  logic [PORT_W-1:0] lat_port;
  logic [TIME_W-1:0] lat_now;

  // walk state
  logic [CW-1:0]     iss;        // next entry to read
  logic [CW-1:0]     wr;         // next compacted slot
  logic              dv;         // ram read data belongs to entry iss - 1
  logic              matched;    // request sender already in the table
  logic [IP_W-1:0]   first_ip;   // row 0 after compaction
  logic [PORT_W-1:0] first_port;

  // table ram
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  entry_t         ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t         rd_entry;

  // shared age unit and decision logic
  logic              hit;
  logic [TIME_W-1:0] seen_eff;
  logic [TIME_W-1:0] sub_b;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] win32;
  logic              keep;
  logic              grace;
  logic              add_new;
  logic              issue;
  logic              res_load;
  mode_t             mode_next;
  logic              held_valid_next;
  logic [COUNT_OUT_W-1:0] shown;

  assign in_ready = (state == S_IDLE);
  // result register takes the decision once it is empty or draining
  assign res_load = (state == S_DONE) && (!out_valid || out_ready);

  ast_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_entry = entry_t'(ram_rdata);
    // a refreshed row gets the request time before its age is taken
    hit      = lat_pixel && (rd_entry.ip == lat_ip) && (rd_entry.port == lat_port);
    seen_eff = hit ? lat_now : rd_entry.seen;
    // one subtractor: row age while walking, time since link up when deciding
    sub_b    = (state == S_DONE) ? link_up_time_ms : seen_eff;
    age      = lat_now - sub_b;
    win32    = {{(TIME_W - WINDOW_W){1'b0}}, window_ms};
    keep     = (age <= win32);
    grace    = (last_pixel_ms == '0) && (link_up_time_ms != '0) && (age < win32);
    // new sender only goes in if the table had room before expiry
    add_new  = lat_pixel && !matched && (entry_count < CW'(TABLE_DEPTH));
    issue    = (state == S_SCAN) && (iss < entry_count);
  end

  // ram write port: compacted rows while walking, new row at the tail
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr[AW-1:0];
    ram_wdata = '{ip: rd_entry.ip, port: rd_entry.port, seen: seen_eff};
    case (state)
      S_SCAN: begin
        ram_we = dv && keep;
      end
      S_TAIL: begin
        ram_we    = add_new;
        ram_wdata = '{ip: lat_ip, port: lat_port, seen: lat_now};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // mode choice from the settled fill count
  always_comb begin
    if (entry_count > CW'(1)) begin
      mode_next       = MODE_CONFLICT;
      held_valid_next = 1'b0;
    end else if (entry_count == CW'(1)) begin
      mode_next       = MODE_NORMAL;
      held_valid_next = 1'b1;
    end else begin
      mode_next       = grace ? MODE_NORMAL : MODE_IDLE;
      held_valid_next = 1'b0;
    end
    // count field saturates for deep tables
    if (32'(entry_count) > 32'd15) begin
      shown = 4'd15;
    end else begin
      shown = COUNT_OUT_W'(entry_count);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms       <= WINDOW_RESET;
      link_up_time_ms <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW:  window_ms       <= cfg_data[WINDOW_W-1:0];
        REG_LINK_UP: link_up_time_ms <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request latch and walk datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lat_pixel <= ~action;
      lat_ip    <= src_addr;
      lat_port  <= src_port;
      lat_now   <= now_ms;
    end
    if (ram_we && (wr == '0)) begin
      first_ip   <= ram_wdata.ip;
      first_port <= ram_wdata.port;
    end
  end

  // sequencer and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      last_pixel_ms <= '0;
      current_mode  <= MODE_NORMAL;
      iss           <= '0;
      wr            <= '0;
      dv            <= 1'b0;
      matched       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // result register fills on load, drains on accept
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      dv <= issue;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            iss     <= '0;
            wr      <= '0;
            matched <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (dv) begin
            if (hit) begin
              matched <= 1'b1;
            end
            if (keep) begin
              wr <= wr + CW'(1);
            end
          end
          if (issue) begin
            iss <= iss + CW'(1);
          end else begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          entry_count <= add_new ? (wr + CW'(1)) : wr;
          if (lat_pixel) begin
            last_pixel_ms <= lat_now;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // wait for the result register to free up
          if (res_load) begin
            current_mode <= mode_next;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      mode         <= mode_next;
      mode_changed <= (mode_next != current_mode);
      remote_valid <= held_valid_next;
      peer_addr    <= held_valid_next ? first_ip : '0;
      peer_port    <= held_valid_next ? first_port : '0;
      active_count <= shown;
      announce     <= lat_pixel && (current_mode == MODE_IDLE) &&
                      (mode_next == MODE_NORMAL) && held_valid_next;
    end
  end

  // checks
  `AST_ASSERT_NEXT(a_accept_walks, clk, rst, in_valid && in_ready, state == S_SCAN)
  `AST_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, entry_count <= CW'(TABLE_DEPTH))
  `AST_ASSERT_IMPL(a_compact_behind, clk, rst, state == S_SCAN, wr <= iss)
  `AST_ASSERT_IMPL(a_remote_single, clk, rst, out_valid && remote_valid,
                   active_count == 4'd1 && mode == MODE_NORMAL)

endmodule

`default_nettype wire

FILE: hw/rtl/ast_ram.sv
`default_nettype none

module ast_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
